[hdl/anaglyph_pixel_shift_macros.svh]
// assertion shorthands used by the checker file asp_checker.sv
`ifndef ANAGLYPH_PIXEL_SHIFT_MACROS_SVH
`define ANAGLYPH_PIXEL_SHIFT_MACROS_SVH

// checked only outside reset
`define ASP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("anaglyph pixel shift: assertion failed");

// checked at every edge, reset included
`define ASP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("anaglyph pixel shift: reset assertion failed");

`endif

[hdl/asp_pkg.sv]
package asp_pkg;

  localparam int unsigned MaxShiftDef = 31;
  localparam int unsigned MaxLineDef  = 4096;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned PixW     = 3 * ChanW;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;

  typedef enum logic [ModeW-1:0] {
    ModeRedBlue  = 2'd0,
    ModeRedCyan  = 2'd1,
    ModeAvgGreen = 2'd2,
    ModeGrey     = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode  = 1'b0,
    CfgShift = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StRun   = 2'b01,
    StFlush = 2'b10
  } fsm_e;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } pixel_t;

  localparam mode_e             ModeReset  = ModeRedCyan;
  localparam logic [ShiftW-1:0] ShiftReset = 5'd30;

endpackage

[hdl/asp_ifs.sv]
interface asp_pix_in_if;
  logic                      valid;
  logic                      ready;
  logic [asp_pkg::ChanW-1:0] red;
  logic [asp_pkg::ChanW-1:0] green;
  logic [asp_pkg::ChanW-1:0] blue;
  logic                      last_in_line;

  modport source (output valid, output red, output green, output blue,
                  output last_in_line, input ready);
  modport sink (input valid, input red, input green, input blue,
                input last_in_line, output ready);
endinterface

interface asp_pix_out_if;
  logic                      valid;
  logic                      ready;
  logic [asp_pkg::ChanW-1:0] out_red;
  logic [asp_pkg::ChanW-1:0] out_green;
  logic [asp_pkg::ChanW-1:0] out_blue;
  logic                      line_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output line_end, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input line_end, output ready);
endinterface

interface asp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [asp_pkg::CfgIdxW-1:0]  index;
  logic [asp_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/anaglyph_pixel_shift.sv]
// Anaglyph pixel shift: takes RGB pixels one line at a time and returns the false-color
// anaglyph of the line, where output pixel p takes red from input p-shift and the other
// channels from input p+shift as the mode selects; pixels within shift of either line end
// pass through. Results lag the input by shift pixels. One pixel is accepted per clock
// unless the output stalls; after the pixel marked last_in_line the input stalls while
// the tail is read back, one read per remaining pixel, through one of the window memory's
// two read ports. Each pixel passes the memory read register, then the result register.
// Shift is latched at the first pixel of each line; mode takes effect at once. The user
// must write both registers only while the block is idle; the block does not enforce it.
module anaglyph_pixel_shift #(
  parameter int unsigned MaxShift = asp_pkg::MaxShiftDef,
  parameter int unsigned MaxLine  = asp_pkg::MaxLineDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  asp_cfg_if.sink        cfg_i,
  asp_pix_in_if.sink     pix_i,
  asp_pix_out_if.source  res_o
);

  localparam int unsigned AddrW = $clog2(2 * MaxShift + 1);
  localparam int unsigned Depth = 2 ** AddrW;
  localparam int unsigned PosW  = $clog2(MaxLine);
  localparam int unsigned CmpW  = PosW + 1;
  localparam int unsigned SW    = asp_pkg::ShiftW;
  localparam logic [SW-1:0]   MaxShiftS = SW'(MaxShift);
  localparam logic [PosW-1:0] PosMax    = PosW'(MaxLine - 1);

  typedef struct packed {
    logic emit;
    logic pass;
    logic bypass;
    logic line_end;
  } s1_ctl_t;

  // configuration
  asp_pkg::mode_e  mode_q;
  logic [SW-1:0]   shift_q;

  // line control
  asp_pkg::fsm_e   state_q, state_d;
  logic [PosW-1:0] pos_q;
  logic [SW-1:0]   line_shift_q;
  logic [AddrW-1:0] wp_q;
  logic [SW-1:0]   flush_idx_q, flush_idx_d;

  // window memory
  asp_pkg::pixel_t mem_q [Depth];
  asp_pkg::pixel_t rd_p_q, rd_l_q;

  // read stage
  logic            s1_valid_q;
  s1_ctl_t         s1_q, s1_d;
  asp_pkg::pixel_t in_pix_q;

  // result register
  logic            res_valid_q;
  asp_pkg::pixel_t res_pix_q, res_pix_d;
  logic            res_end_q;

  logic            out_free, s1_adv, in_ready, in_acc, flush_iss, issue;
  logic [SW-1:0]   line_s;
  logic [AddrW-1:0] s_a, wp_new, rd_addr_p, rd_addr_l;
  logic [CmpW-1:0] q_ext, s_ext, s2_ext;
  logic            q_ge_s;
  asp_pkg::pixel_t pix_in, pp, left, right;
  logic [asp_pkg::ChanW:0] g_sum;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= asp_pkg::ModeReset;
      shift_q <= asp_pkg::ShiftReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        asp_pkg::CfgMode:  mode_q  <= asp_pkg::mode_e'(cfg_i.data[asp_pkg::ModeW-1:0]);
        asp_pkg::CfgShift: shift_q <= cfg_i.data[SW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free  = !res_valid_q || res_o.ready;
  assign s1_adv    = !s1_valid_q || !s1_q.emit || out_free;
  assign in_ready  = (state_q == asp_pkg::StRun) && s1_adv;
  assign in_acc    = pix_i.valid && in_ready;
  assign flush_iss = (state_q == asp_pkg::StFlush) && s1_adv;
  assign issue     = in_acc || flush_iss;
  assign pix_i.ready = in_ready;

  assign pix_in = '{r: pix_i.red, g: pix_i.green, b: pix_i.blue};

  // shift is latched at the first pixel of a line
  always_comb begin
    if (pos_q == '0) begin
      line_s = (shift_q > MaxShiftS) ? MaxShiftS : shift_q;
    end else begin
      line_s = line_shift_q;
    end
  end

  assign s_a       = AddrW'(line_s);
  assign wp_new    = wp_q + AddrW'(1);
  assign rd_addr_p = in_acc ? (wp_new - s_a) : (wp_q - AddrW'(flush_idx_q));
  assign rd_addr_l = wp_new - (s_a << 1);

  assign q_ext  = CmpW'(pos_q);
  assign s_ext  = CmpW'(line_s);
  assign s2_ext = s_ext << 1;
  assign q_ge_s = (q_ext >= s_ext);

  always_comb begin
    state_d     = state_q;
    flush_idx_d = flush_idx_q;
    s1_d        = s1_q;
    if (in_acc) begin
      s1_d.emit     = q_ge_s;
      s1_d.pass     = (q_ext < s2_ext);
      // zero shift reads the entry being written, take it from the input register
      s1_d.bypass   = (line_s == '0);
      s1_d.line_end = pix_i.last_in_line && (line_s == '0);
      if (pix_i.last_in_line && (line_s != '0)) begin
        state_d     = asp_pkg::StFlush;
        flush_idx_d = q_ge_s ? (line_s - SW'(1)) : SW'(pos_q);
      end
    end else if (flush_iss) begin
      s1_d.emit     = 1'b1;
      s1_d.pass     = 1'b1;
      s1_d.bypass   = 1'b0;
      s1_d.line_end = (flush_idx_q == '0);
      if (flush_idx_q == '0) begin
        state_d = asp_pkg::StRun;
      end else begin
        flush_idx_d = flush_idx_q - SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= asp_pkg::StRun;
      flush_idx_q  <= '0;
      pos_q        <= '0;
      line_shift_q <= '0;
      wp_q         <= '0;
      s1_valid_q   <= 1'b0;
      s1_q         <= '0;
    end else begin
      state_q     <= state_d;
      flush_idx_q <= flush_idx_d;
      if (in_acc) begin
        line_shift_q <= line_s;
        wp_q         <= wp_new;
        if (pix_i.last_in_line) begin
          pos_q <= '0;
        end else if (pos_q < PosMax) begin
          pos_q <= pos_q + PosW'(1);
        end
      end
      if (issue) begin
        s1_valid_q <= 1'b1;
        s1_q       <= s1_d;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem_q[wp_new] <= pix_in;
      in_pix_q      <= pix_in;
    end
    if (issue) begin
      rd_p_q <= mem_q[rd_addr_p];
      rd_l_q <= mem_q[rd_addr_l];
    end
  end

  assign pp    = s1_q.bypass ? in_pix_q : rd_p_q;
  assign left  = s1_q.bypass ? in_pix_q : rd_l_q;
  assign right = in_pix_q;
  assign g_sum = {1'b0, left.g} + {1'b0, right.g};

  always_comb begin
    if (s1_q.pass) begin
      res_pix_d = pp;
    end else begin
      res_pix_d = '{r: left.r, g: right.g, b: right.b};
      case (mode_q)
        asp_pkg::ModeRedBlue:  res_pix_d.g = '0;
        asp_pkg::ModeRedCyan:  ;
        asp_pkg::ModeAvgGreen: res_pix_d.g = g_sum[asp_pkg::ChanW:1];
        asp_pkg::ModeGrey: begin
          res_pix_d.r = left.b;
          res_pix_d.g = right.b;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_valid_q && s1_q.emit && out_free) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_q.emit && out_free) begin
      res_pix_q <= res_pix_d;
      res_end_q <= s1_q.line_end;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.out_red   = res_pix_q.r;
  assign res_o.out_green = res_pix_q.g;
  assign res_o.out_blue  = res_pix_q.b;
  assign res_o.line_end  = res_end_q;

endmodule

[hdl/asp_checker.sv]
`include "anaglyph_pixel_shift_macros.svh"

module asp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_last_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_line_end_i,
  input logic [asp_pkg::PixW-1:0]   out_pix_i
);

  logic       in_last_acc, out_end_acc;
  logic [2:0] open_lines_q;

  assign in_last_acc = in_valid_i && in_ready_i && in_last_i;
  assign out_end_acc = out_valid_i && out_ready_i && out_line_end_i;

  // lines whose last pixel went in but whose line end has not come out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_lines_q <= '0;
    end else if (in_last_acc && !out_end_acc) begin
      open_lines_q <= open_lines_q + 3'd1;
    end else if (out_end_acc && !in_last_acc) begin
      open_lines_q <= open_lines_q - 3'd1;
    end
  end

  `ASP_ASSERT(a_out_valid_held, out_valid_i && !out_ready_i |=> out_valid_i)
  `ASP_ASSERT(a_out_pix_held, out_valid_i && !out_ready_i |=> $stable(out_pix_i))
  `ASP_ASSERT(a_line_end_has_line, out_end_acc |-> (open_lines_q != 3'd0))
  `ASP_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |=> !out_valid_i)

endmodule

bind anaglyph_pixel_shift asp_checker u_asp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (pix_i.valid),
  .in_ready_i     (pix_i.ready),
  .in_last_i      (pix_i.last_in_line),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .out_line_end_i (res_o.line_end),
  .out_pix_i      ({res_o.out_red, res_o.out_green, res_o.out_blue})
);
